[src/mf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf_pkg: shared widths, constants and types of the moments finalizer
// Field widths of the stream payload and of the internal datapath.
// ----------------------------------------------------------------------------
package mf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 20;
  localparam int FRAC_BITS   = 8;

  localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_W   = 2 * SAMPLE_BITS + COUNT_BITS - 1;
  localparam int CNT_W  = COUNT_BITS + 1;
  localparam int MEAN_W = SAMPLE_BITS + FRAC_BITS;
  localparam int VAR_W  = 2 * SAMPLE_BITS + FRAC_BITS - 1;
  localparam int SIG_W  = SAMPLE_BITS + FRAC_BITS;

  localparam int IN_W  = 112;
  localparam int OUT_W = 112;

  // Datapath widths.
  localparam int PROD_W    = CNT_W + SQ_W;
  localparam int SQ_SPLIT  = 26;
  localparam int ALO_W     = CNT_W + SQ_SPLIT;
  localparam int AHI_W     = CNT_W + SQ_W - SQ_SPLIT;
  localparam int MAG_SPLIT = 18;
  localparam int MHI_W     = SUM_W - MAG_SPLIT;
  localparam int BP_W      = 2 * MAG_SPLIT;
  localparam int X_W       = 88;
  localparam int D_W       = 2 * CNT_W;
  localparam int Q_W       = 2 * SIG_W;
  localparam int XH_W      = X_W - Q_W;
  localparam int REM_W     = SIG_W + 2;

  localparam int PREP_STAGES = 3;
  localparam int DIV_STAGES  = Q_W + 1;
  localparam int SQRT_STAGES = SIG_W;
  localparam int LATENCY     = PREP_STAGES + DIV_STAGES + SQRT_STAGES + 1;

  typedef struct packed {
    logic neg;
    logic has_pts;
    logic var_ok;
  } side_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]  variance;
    logic              has_pts;
    logic              var_ok;
  } post_t;

endpackage

[src/mf_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf_prep: front end of the moments finalizer
// Forms n*sum_squares - sum^2, n*(n-1) and the three dividends in three stages.
// ----------------------------------------------------------------------------
module mf_prep import mf_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [SUM_W-1:0] sum,
  input  logic [SQ_W-1:0]  sum_squares,
  input  logic [CNT_W-1:0] count,
  output logic [X_W-1:0]   x_mean,
  output logic [X_W-1:0]   x_rms,
  output logic [X_W-1:0]   x_var,
  output logic [D_W-1:0]   d_cnt,
  output logic [D_W-1:0]   d_pair,
  output side_t            side
);

  logic [SUM_W-1:0] mag_in;

  // Stage B: magnitude and partial products.
  logic [SUM_W-1:0] mag_b;
  logic [SQ_W-1:0]  sq_b;
  logic [CNT_W-1:0] cnt_b;
  logic             neg_b, ge1_b, ge2_b;
  logic [ALO_W-1:0] alo_b;
  logic [AHI_W-1:0] ahi_b;
  logic [BP_W-1:0]  bhh_b, bhl_b, bll_b;
  logic [D_W-1:0]   den_b;

  // Stage C: full products.
  logic [SUM_W-1:0]  mag_c;
  logic [SQ_W-1:0]   sq_c;
  logic [CNT_W-1:0]  cnt_c;
  logic              neg_c, ge1_c, ge2_c;
  logic [PROD_W-1:0] a_c, b_c;
  logic [D_W-1:0]    den_c;

  assign mag_in = sum[SUM_W-1] ? (SUM_W'(0) - sum) : sum;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_b <= mag_in;
      sq_b  <= sum_squares;
      cnt_b <= count;
      neg_b <= sum[SUM_W-1];
      ge1_b <= (count >= CNT_W'(1));
      ge2_b <= (count >= CNT_W'(2));
      alo_b <= ALO_W'(count) * ALO_W'(sum_squares[SQ_SPLIT-1:0]);
      ahi_b <= AHI_W'(count) * AHI_W'(sum_squares[SQ_W-1:SQ_SPLIT]);
      bhh_b <= BP_W'(mag_in[SUM_W-1:MAG_SPLIT]) * BP_W'(mag_in[SUM_W-1:MAG_SPLIT]);
      bhl_b <= BP_W'(mag_in[SUM_W-1:MAG_SPLIT]) * BP_W'(mag_in[MAG_SPLIT-1:0]);
      bll_b <= BP_W'(mag_in[MAG_SPLIT-1:0]) * BP_W'(mag_in[MAG_SPLIT-1:0]);
      den_b <= D_W'(count) * D_W'(CNT_W'(count - CNT_W'(1)));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_c <= mag_b;
      sq_c  <= sq_b;
      cnt_c <= cnt_b;
      neg_c <= neg_b;
      ge1_c <= ge1_b;
      ge2_c <= ge2_b;
      den_c <= den_b;
      a_c   <= (PROD_W'(ahi_b) << SQ_SPLIT) + PROD_W'(alo_b);
      b_c   <= (PROD_W'(bhh_b) << (2 * MAG_SPLIT)) + (PROD_W'(bhl_b) << (MAG_SPLIT + 1))
               + PROD_W'(bll_b);
    end
  end

  // Stage D: difference and dividends, scaled for the Q.8 and Q.16 quotients.
  always_ff @(posedge clk) begin
    if (en) begin
      x_mean       <= X_W'(mag_c) << FRAC_BITS;
      x_rms        <= X_W'(sq_c) << (2 * FRAC_BITS);
      x_var        <= X_W'(a_c - b_c) << (2 * FRAC_BITS);
      d_cnt        <= D_W'(cnt_c);
      d_pair       <= den_c;
      side.neg     <= neg_c;
      side.has_pts <= ge1_c;
      side.var_ok  <= ge2_c & (b_c < a_c);
    end
  end

endmodule

[src/mf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf_div: pipelined restoring divider
// One quotient bit per stage; an entry stage flags quotients beyond Q_W bits.
// ----------------------------------------------------------------------------
module mf_div import mf_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [X_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic [Q_W-1:0] quotient,
  output logic           sat
);

  logic [D_W-1:0] rem   [0:DIV_STAGES-1];
  logic [Q_W-1:0] shreg [0:DIV_STAGES-1];
  logic [D_W-1:0] dv    [0:DIV_STAGES-1];
  logic           ovf   [0:DIV_STAGES-1];
  logic           ovf_in;

  assign ovf_in = D_W'(dividend[X_W-1:Q_W]) >= divisor;

  always_ff @(posedge clk) begin
    if (en) begin
      ovf[0]   <= ovf_in;
      rem[0]   <= ovf_in ? '0 : D_W'(dividend[X_W-1:Q_W]);
      shreg[0] <= dividend[Q_W-1:0];
      dv[0]    <= divisor;
    end
  end

  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_step
    logic [D_W:0] trial;
    logic         ge;
    logic [D_W:0] diff;
    assign trial = {rem[k-1], shreg[k-1][Q_W-1]};
    assign ge    = trial >= {1'b0, dv[k-1]};
    assign diff  = trial - {1'b0, dv[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]   <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
        shreg[k] <= {shreg[k-1][Q_W-2:0], ge};
        dv[k]    <= dv[k-1];
        ovf[k]   <= ovf[k-1];
      end
    end
  end

  assign quotient = shreg[DIV_STAGES-1];
  assign sat      = ovf[DIV_STAGES-1];

endmodule

[src/mf_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf_sqrt: pipelined integer square root
// Digit-by-digit method, one root bit per stage, truncated result.
// ----------------------------------------------------------------------------
module mf_sqrt import mf_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [Q_W-1:0]   radicand,
  output logic [SIG_W-1:0] root
);

  logic [REM_W-1:0] rem  [0:SQRT_STAGES-1];
  logic [SIG_W-1:0] rt   [0:SQRT_STAGES-1];
  logic [Q_W-1:0]   xs   [0:SQRT_STAGES-1];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_step
    logic [REM_W-1:0] rem_in;
    logic [SIG_W-1:0] rt_in;
    logic [Q_W-1:0]   xs_in;
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic             ge;
    logic [REM_W+1:0] diff;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign rt_in  = '0;
      assign xs_in  = radicand;
    end else begin : g_next
      assign rem_in = rem[j-1];
      assign rt_in  = rt[j-1];
      assign xs_in  = xs[j-1];
    end

    assign cur   = {rem_in, xs_in[Q_W-1:Q_W-2]};
    assign trial = (REM_W+2)'({rt_in, 2'b01});
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
        rt[j]  <= {rt_in[SIG_W-2:0], ge};
        xs[j]  <= {xs_in[Q_W-3:0], 2'b00};
      end
    end
  end

  assign root = rt[SQRT_STAGES-1];

endmodule

[src/moments_finalizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moments_finalizer: sample statistics from accumulated sums
// Turns sum, sum of squares and count into mean, variance, sigma and rms.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ group carries one set of accumulated sums; each
//   request on the m_ group carries the matching statistics, in order, in
//   Q.8 fixed point truncated toward zero and saturated at the field limits.
//   Mean and rms are zero for an empty count, variance and sigma are zero
//   below two samples or when the variance is not positive.
//   Throughput is one request per cycle unless the receiver stalls. Three
//   front-end stages form the products, a 49-stage divider (an entry stage,
//   then one quotient bit per stage) yields the quotients, a 24-stage root
//   pipeline (one root bit per stage) follows; the output register adds one more.
//   All stages advance together on one enable. When the receiver stalls
//   with a result waiting, the whole pipeline holds and s_tready drops in
//   the same cycle; nothing is lost or repeated. Reset clears the valid bits
//   of every stage, so the output comes up empty and the input ready.
// ----------------------------------------------------------------------------
module moments_finalizer import mf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // s_tdata: sum[35:0], sum_squares[86:36], count[107:87], zero[111:108]
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // m_tdata: mean[23:0], variance[62:24], sigma[86:63], rms[110:87], zero[111]
  output logic [OUT_W-1:0] m_tdata,
  // m_tuser: has_points[0]
  output logic [0:0]       m_tuser
);

  logic en;

  // One valid bit per pipeline stage, the last one is the output register.
  logic [LATENCY-1:0] vld;

  logic [X_W-1:0] x_mean, x_rms, x_var;
  logic [D_W-1:0] d_cnt, d_pair;
  side_t          side;

  logic [Q_W-1:0] q_mean, q_rms, q_var;
  logic           s_mean, s_rms, s_var;

  // Side flags ride alongside the divider; final mean and variance ride
  // alongside the root pipeline.
  side_t side_pipe [0:DIV_STAGES-1];
  post_t post_pipe [0:SQRT_STAGES-1];
  post_t post_in;

  logic [Q_W-1:0]    rad_rms, rad_sig;
  logic [SIG_W-1:0]  root_rms, root_sig;
  logic [MEAN_W-1:0] mag_mean;
  logic              big_mean;

  logic [MEAN_W-1:0] mean_r;
  logic [VAR_W-1:0]  var_r;
  logic [SIG_W-1:0]  sig_r, rms_r;
  logic              pts_r;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LATENCY-2:0], s_tvalid};
    end
  end

  mf_prep u_prep (
    .clk         (clk),
    .en          (en),
    .sum         (s_tdata[SUM_W-1:0]),
    .sum_squares (s_tdata[SUM_W+SQ_W-1:SUM_W]),
    .count       (s_tdata[SUM_W+SQ_W+CNT_W-1:SUM_W+SQ_W]),
    .x_mean      (x_mean),
    .x_rms       (x_rms),
    .x_var       (x_var),
    .d_cnt       (d_cnt),
    .d_pair      (d_pair),
    .side        (side)
  );

  mf_div u_div_mean (
    .clk (clk), .en (en), .dividend (x_mean), .divisor (d_cnt),
    .quotient (q_mean), .sat (s_mean)
  );

  mf_div u_div_rms (
    .clk (clk), .en (en), .dividend (x_rms), .divisor (d_cnt),
    .quotient (q_rms), .sat (s_rms)
  );

  // The variance quotient is taken in Q.16; dropping eight bits gives the
  // exact Q.8 variance, and the Q.16 value is the radicand for sigma.
  mf_div u_div_var (
    .clk (clk), .en (en), .dividend (x_var), .divisor (d_pair),
    .quotient (q_var), .sat (s_var)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_pipe[0] <= side;
      for (int i = 1; i < DIV_STAGES; i++) begin
        side_pipe[i] <= side_pipe[i-1];
      end
    end
  end

  // Mean saturates at +2^23-1, or at -2^23 for a negative sum.
  always_comb begin
    big_mean = s_mean || (q_mean > Q_W'({1'b0, {(MEAN_W-1){1'b1}}}));
    mag_mean = big_mean ? {1'b1, {(MEAN_W-1){1'b0}}} : q_mean[MEAN_W-1:0];
    if (side_pipe[DIV_STAGES-1].neg) begin
      big_mean = s_mean || (q_mean > Q_W'({1'b1, {(MEAN_W-1){1'b0}}}));
      mag_mean = big_mean ? {1'b1, {(MEAN_W-1){1'b0}}} : q_mean[MEAN_W-1:0];
      post_in.mean = MEAN_W'(0) - mag_mean;
    end else begin
      post_in.mean = big_mean ? {1'b0, {(MEAN_W-1){1'b1}}} : q_mean[MEAN_W-1:0];
    end
    if (!side_pipe[DIV_STAGES-1].has_pts) begin
      post_in.mean = '0;
    end
    if (!side_pipe[DIV_STAGES-1].var_ok) begin
      post_in.variance = '0;
    end else if (s_var || q_var[Q_W-1]) begin
      post_in.variance = '1;
    end else begin
      post_in.variance = q_var[Q_W-2:FRAC_BITS];
    end
    post_in.has_pts = side_pipe[DIV_STAGES-1].has_pts;
    post_in.var_ok  = side_pipe[DIV_STAGES-1].var_ok;
  end

  // A quotient past Q_W bits maps to the all-ones radicand, whose root is
  // the saturated sigma or rms.
  assign rad_rms = s_rms ? '1 : q_rms;
  assign rad_sig = s_var ? '1 : q_var;

  mf_sqrt u_sqrt_rms (.clk (clk), .en (en), .radicand (rad_rms), .root (root_rms));
  mf_sqrt u_sqrt_sig (.clk (clk), .en (en), .radicand (rad_sig), .root (root_sig));

  always_ff @(posedge clk) begin
    if (en) begin
      post_pipe[0] <= post_in;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        post_pipe[i] <= post_pipe[i-1];
      end
    end
  end

  // Output register: it holds a result while the receiver stalls.
  always_ff @(posedge clk) begin
    if (en) begin
      mean_r <= post_pipe[SQRT_STAGES-1].mean;
      var_r  <= post_pipe[SQRT_STAGES-1].variance;
      sig_r  <= post_pipe[SQRT_STAGES-1].var_ok ? root_sig : '0;
      rms_r  <= post_pipe[SQRT_STAGES-1].has_pts ? root_rms : '0;
      pts_r  <= post_pipe[SQRT_STAGES-1].has_pts;
    end
  end

  assign m_tvalid = vld[LATENCY-1];
  assign m_tdata  = {1'b0, rms_r, sig_r, var_r, mean_r};
  assign m_tuser  = pts_r;

endmodule

[src/mf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf_checker: port-level checks for the moments finalizer
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module mf_checker import mf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic [0:0]       m_tuser
);

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown right after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // With the output empty, the block takes a request.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  // An empty count gives zero mean and rms.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[23:0] == '0 && m_tdata[110:87] == '0)
    else $error("nonzero mean or rms for empty count");

  // A nonzero sigma needs samples.
  a_sigma: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[86:63] != '0 |-> m_tuser[0])
    else $error("sigma without samples");

endmodule

bind moments_finalizer mf_checker u_mf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
